@@ design/ncisl_pkg.sv @@
package ncisl_pkg;

   localparam int COMMENT_DEPTH_BITS = 8;
   localparam int BRACE_DEPTH_BITS   = 8;
   localparam int DEPTH_OUT_BITS     = 8;

   // both queues are two entries deep
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COMMENT_DEPTH_BITS-1:0] CDEPTH_ONE = COMMENT_DEPTH_BITS'(1);
   localparam logic [BRACE_DEPTH_BITS-1:0]   BDEPTH_ONE = BRACE_DEPTH_BITS'(1);

   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_DOLLAR    = 8'h24;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;

   localparam int ALLOW_COMMENT_BIT = 0;
   localparam int ALLOW_STRING_BIT  = 1;

   typedef enum logic [3:0] {
      CC_OTHER,
      CC_SPACE,
      CC_LPAREN,
      CC_STAR,
      CC_RPAREN,
      CC_DOLLAR,
      CC_QUOTE,
      CC_BACKSLASH,
      CC_LBRACE,
      CC_RBRACE,
      CC_END
   } char_class_type;

   typedef enum logic [2:0] {
      ST_SKIP,
      ST_IN,
      ST_COMMENT,
      ST_STRING,
      ST_NOMATCH,
      ST_UNTERM,
      ST_OVER
   } status_type;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_C_OPEN,
      MODE_COMMENT,
      MODE_C_PAREN,
      MODE_C_STAR,
      MODE_S_OPEN,
      MODE_STR,
      MODE_STR_ESC,
      MODE_STR_DOLLAR,
      MODE_INTERP,
      MODE_NEST,
      MODE_NEST_ESC
   } scan_mode_type;

   typedef struct packed {
      char_class_type cls;
      logic [1:0]     allow;
   } lex_item_type;

   typedef struct packed {
      logic         valid;
      lex_item_type item;
   } lex_chan_type;

   function automatic char_class_type classify(input logic [7:0] c, input logic eoi);
      char_class_type cls;
      begin
         cls = CC_OTHER;
         if (eoi) cls = CC_END;
         else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) cls = CC_SPACE;
         else if (c == CH_LPAREN) cls = CC_LPAREN;
         else if (c == CH_STAR) cls = CC_STAR;
         else if (c == CH_RPAREN) cls = CC_RPAREN;
         else if (c == CH_DOLLAR) cls = CC_DOLLAR;
         else if (c == CH_QUOTE) cls = CC_QUOTE;
         else if (c == CH_BACKSLASH) cls = CC_BACKSLASH;
         else if (c == CH_LBRACE) cls = CC_LBRACE;
         else if (c == CH_RBRACE) cls = CC_RBRACE;
         return cls;
      end
   endfunction

endpackage

@@ design/ncisl_front.sv @@
module ncisl_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_char_byte,
   input  logic                  req_end_of_input,
   input  logic [1:0]            req_allowed_tokens,
   input  logic                  req_push,
   output logic                  req_full,
   output ncisl_pkg::lex_chan_type chan,
   input  logic                  chan_ready
);
   import ncisl_pkg::*;

   lex_item_type         fq_mem [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_push, do_pop;
   lex_item_type         new_item;

   assign req_full = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign do_push  = req_push && !req_full;
   assign do_pop   = chan.valid && chan_ready;

   always_comb begin
      new_item.cls   = classify(req_char_byte, req_end_of_input);
      new_item.allow = req_allowed_tokens;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) fq_mem[wr_ptr_ff] <= new_item;
   end

   always_comb begin
      chan.valid = (count_ff != '0);
      chan.item  = fq_mem[rd_ptr_ff];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("front queue count out of range");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("front queue lost a transfer");

   a_pop_counts: assert property (@(posedge clock) disable iff (reset)
      (!do_push && do_pop) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("front queue repeated a transfer");

endmodule

@@ design/ncisl_back.sv @@
module ncisl_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ncisl_pkg::lex_chan_type chan,
   output logic                    chan_ready,
   output logic [2:0]              rsp_status,
   output logic [7:0]              rsp_nesting_depth,
   output logic                    rsp_empty,
   input  logic                    rsp_pop
);
   import ncisl_pkg::*;

   typedef struct packed {
      status_type                 status;
      logic [DEPTH_OUT_BITS-1:0]  depth;
   } result_type;

   scan_mode_type                  mode_ff, mode_in;
   logic [COMMENT_DEPTH_BITS-1:0]  cdepth_ff, cdepth_in;
   logic [BRACE_DEPTH_BITS-1:0]    bdepth_ff, bdepth_in;

   result_type           rq_mem [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   logic           step, do_pop;
   char_class_type cls;
   logic [1:0]     allow;
   logic           go_idle;
   status_type     status;
   result_type     result;

   assign cls        = chan.item.cls;
   assign allow      = chan.item.allow;
   assign chan_ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign step       = chan.valid && chan_ready;
   assign do_pop     = rsp_pop && !rsp_empty;

   // next state of the scanner
   always_comb begin
      mode_in   = mode_ff;
      cdepth_in = cdepth_ff;
      bdepth_in = bdepth_ff;
      go_idle   = 1'b0;
      if (cls == CC_END) begin
         go_idle = 1'b1;
      end else begin
         case (mode_ff)
            MODE_C_OPEN: begin
               if (cls == CC_STAR) begin
                  cdepth_in = CDEPTH_ONE;
                  mode_in   = MODE_COMMENT;
               end else go_idle = 1'b1;
            end
            MODE_COMMENT, MODE_C_PAREN, MODE_C_STAR: begin
               if (mode_ff == MODE_C_PAREN && cls == CC_STAR) begin
                  if (&cdepth_ff) go_idle = 1'b1;
                  else begin
                     cdepth_in = cdepth_ff + CDEPTH_ONE;
                     mode_in   = MODE_COMMENT;
                  end
               end else if (mode_ff == MODE_C_STAR && cls == CC_RPAREN) begin
                  if (cdepth_ff <= CDEPTH_ONE) go_idle = 1'b1;
                  else begin
                     cdepth_in = cdepth_ff - CDEPTH_ONE;
                     mode_in   = MODE_COMMENT;
                  end
               end else if (cls == CC_LPAREN) mode_in = MODE_C_PAREN;
               else if (cls == CC_STAR) mode_in = MODE_C_STAR;
               else mode_in = MODE_COMMENT;
            end
            MODE_S_OPEN: begin
               if (cls == CC_QUOTE) mode_in = MODE_STR;
               else go_idle = 1'b1;
            end
            MODE_STR, MODE_STR_DOLLAR: begin
               if (mode_ff == MODE_STR_DOLLAR && cls == CC_LBRACE) begin
                  bdepth_in = BDEPTH_ONE;
                  mode_in   = MODE_INTERP;
               end else if (cls == CC_QUOTE) go_idle = 1'b1;
               else if (cls == CC_BACKSLASH) mode_in = MODE_STR_ESC;
               else if (cls == CC_DOLLAR) mode_in = MODE_STR_DOLLAR;
               else mode_in = MODE_STR;
            end
            MODE_STR_ESC: mode_in = MODE_STR;
            MODE_INTERP: begin
               if (cls == CC_LBRACE) begin
                  if (&bdepth_ff) go_idle = 1'b1;
                  else bdepth_in = bdepth_ff + BDEPTH_ONE;
               end else if (cls == CC_RBRACE) begin
                  if (bdepth_ff <= BDEPTH_ONE) begin
                     bdepth_in = '0;
                     mode_in   = MODE_STR;
                  end else bdepth_in = bdepth_ff - BDEPTH_ONE;
               end else if (cls == CC_QUOTE) mode_in = MODE_NEST;
            end
            MODE_NEST: begin
               if (cls == CC_BACKSLASH) mode_in = MODE_NEST_ESC;
               else if (cls == CC_QUOTE) mode_in = MODE_INTERP;
            end
            MODE_NEST_ESC: mode_in = MODE_NEST;
            default: begin
               if (cls == CC_LPAREN && allow[ALLOW_COMMENT_BIT]) mode_in = MODE_C_OPEN;
               else if (cls == CC_DOLLAR && allow[ALLOW_STRING_BIT]) mode_in = MODE_S_OPEN;
               else mode_in = MODE_IDLE;
            end
         endcase
      end
      if (go_idle) begin
         mode_in   = MODE_IDLE;
         cdepth_in = '0;
         bdepth_in = '0;
      end
   end

   // status of the current byte
   always_comb begin
      status = ST_IN;
      if (cls == CC_END) begin
         if (mode_ff == MODE_IDLE || mode_ff == MODE_C_OPEN || mode_ff == MODE_S_OPEN)
            status = ST_NOMATCH;
         else status = ST_UNTERM;
      end else begin
         case (mode_ff)
            MODE_C_OPEN: status = (cls == CC_STAR) ? ST_IN : ST_NOMATCH;
            MODE_C_PAREN: status = (cls == CC_STAR && &cdepth_ff) ? ST_OVER : ST_IN;
            MODE_C_STAR: begin
               status = (cls == CC_RPAREN && cdepth_ff <= CDEPTH_ONE) ? ST_COMMENT : ST_IN;
            end
            MODE_S_OPEN: status = (cls == CC_QUOTE) ? ST_IN : ST_NOMATCH;
            MODE_STR: status = (cls == CC_QUOTE) ? ST_STRING : ST_IN;
            MODE_STR_DOLLAR: status = (cls == CC_QUOTE) ? ST_STRING : ST_IN;
            MODE_INTERP: status = (cls == CC_LBRACE && &bdepth_ff) ? ST_OVER : ST_IN;
            MODE_COMMENT, MODE_STR_ESC, MODE_NEST, MODE_NEST_ESC: status = ST_IN;
            default: begin
               if (cls == CC_SPACE) status = ST_SKIP;
               else if (cls == CC_LPAREN && allow[ALLOW_COMMENT_BIT]) status = ST_IN;
               else if (cls == CC_DOLLAR && allow[ALLOW_STRING_BIT]) status = ST_IN;
               else status = ST_NOMATCH;
            end
         endcase
      end
      result.status = status;
      if (mode_in == MODE_COMMENT || mode_in == MODE_C_PAREN || mode_in == MODE_C_STAR)
         result.depth = DEPTH_OUT_BITS'(cdepth_in);
      else result.depth = DEPTH_OUT_BITS'(bdepth_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         cdepth_ff <= '0;
         bdepth_ff <= '0;
      end else if (step) begin
         mode_ff   <= mode_in;
         cdepth_ff <= cdepth_in;
         bdepth_ff <= bdepth_in;
      end
   end

   // result queue
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (step) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (step && !do_pop) count_in = count_ff + 1'b1;
      else if (!step && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) rq_mem[wr_ptr_ff] <= result;
   end

   assign rsp_empty         = (count_ff == '0);
   assign rsp_status        = rq_mem[rd_ptr_ff].status;
   assign rsp_nesting_depth = rq_mem[rd_ptr_ff].depth;

   a_idle_after_end: assert property (@(posedge clock) disable iff (reset)
      (step && (status == ST_OVER || status == ST_UNTERM || status == ST_COMMENT))
      |=> (mode_ff == MODE_IDLE && cdepth_ff == '0 && bdepth_ff == '0))
      else $error("scanner not idle after token end");

   a_comment_depth: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_COMMENT || mode_ff == MODE_C_PAREN || mode_ff == MODE_C_STAR)
      |-> cdepth_ff != '0)
      else $error("zero depth inside comment");

   a_brace_depth: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_INTERP || mode_ff == MODE_NEST || mode_ff == MODE_NEST_ESC)
      |-> bdepth_ff != '0)
      else $error("zero depth inside interpolation");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("result queue count out of range");

endmodule

@@ design/nested_comment_interp_string_lexer_unit.sv @@
// Byte-serial lexer for nested "(*...*)" block comments and "$\"...\"" interpolated strings
// with ${...} sections. One byte per push, one result per byte, in order. A new byte can be
// pushed every cycle while req_full is low: the front end classifies the byte into a
// two-entry queue, the scanner state machine consumes one queued byte per cycle while
// the result queue has room, and writes status and depth into a two-entry result queue,
// so the result of a byte passes through the front queue and then the result queue before
// it can be popped; the sustained rate is one byte per cycle while pop keeps up.
module nested_comment_interp_string_lexer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_char_byte,
   input  logic       req_end_of_input,
   input  logic [1:0] req_allowed_tokens,
   input  logic       req_push,
   output logic       req_full,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_nesting_depth,
   output logic       rsp_empty,
   input  logic       rsp_pop
);
   import ncisl_pkg::*;

   lex_chan_type chan;
   logic         chan_ready;

   ncisl_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_char_byte      (req_char_byte),
      .req_end_of_input   (req_end_of_input),
      .req_allowed_tokens (req_allowed_tokens),
      .req_push           (req_push),
      .req_full           (req_full),
      .chan               (chan),
      .chan_ready         (chan_ready)
   );

   ncisl_back u_back (
      .clock             (clock),
      .reset             (reset),
      .chan              (chan),
      .chan_ready        (chan_ready),
      .rsp_status        (rsp_status),
      .rsp_nesting_depth (rsp_nesting_depth),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop)
   );

endmodule
